// ----- sv/owm_pkg.sv -----
`timescale 1ns / 1ps
// Package for the single-wire bus master byte engine.
// Holds the transfer payload types, the phase encoding, command and status codes,
// register indexes and the duration limit helper. Depends on nothing.
package owm_pkg;

	localparam int TIME_BITS = 10;
	localparam logic [16:0] TIME_MAX = (17'd1 << TIME_BITS) - 17'd1;

	typedef logic [TIME_BITS-1:0] time_t;

	typedef enum logic [3:0] {
		PH_IDLE    = 4'd0,
		PH_RST_LOW = 4'd1,
		PH_RST_REL = 4'd2,
		PH_PRES    = 4'd3,
		PH_RELW    = 4'd4,
		PH_WR_LOW  = 4'd5,
		PH_WR_HOLD = 4'd6,
		PH_WR_GAP  = 4'd7,
		PH_RD_PRE  = 4'd8,
		PH_RD_LOW  = 4'd9,
		PH_RD_WAIT = 4'd10,
		PH_RD_TAIL = 4'd11,
		PH_RD_GAP  = 4'd12
	} phase_t;

	localparam logic [1:0] FUNC_RESET = 2'd0;
	localparam logic [1:0] FUNC_WRITE = 2'd1;
	localparam logic [1:0] FUNC_READ  = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NO_PRES = 2'd1;
	localparam logic [1:0] ST_NO_REL  = 2'd2;

	localparam logic [2:0] REG_RESET_LOW   = 3'd0;
	localparam logic [2:0] REG_RESET_REL   = 3'd1;
	localparam logic [2:0] REG_PRES_LIMIT  = 3'd2;
	localparam logic [2:0] REG_WRITE_LOW   = 3'd3;
	localparam logic [2:0] REG_WRITE_HOLD  = 3'd4;
	localparam logic [2:0] REG_READ_LOW    = 3'd5;
	localparam logic [2:0] REG_READ_SAMPLE = 3'd6;
	localparam logic [2:0] REG_READ_TAIL   = 3'd7;

	localparam int CFG_DATA_BITS = 10;

	typedef struct packed {
		logic       start_req;
		logic [1:0] func;
		logic [7:0] write_data;
		logic       line_level;
	} tick_t;

	typedef struct packed {
		logic       drive_low;
		logic       busy_res;
		logic       done_res;
		logic [7:0] read_data;
		logic [1:0] status;
	} res_t;

	typedef struct packed {
		logic [9:0] reset_low_us;
		logic [9:0] reset_release_us;
		logic [9:0] presence_limit_us;
		logic [5:0] write_low_us;
		logic [7:0] write_hold_us;
		logic [5:0] read_low_us;
		logic [5:0] read_sample_us;
		logic [7:0] read_tail_us;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		reset_low_us:      10'd750,
		reset_release_us:  10'd20,
		presence_limit_us: 10'd240,
		write_low_us:      6'd1,
		write_hold_us:     8'd70,
		read_low_us:       6'd2,
		read_sample_us:    6'd8,
		read_tail_us:      8'd60
	};

	typedef struct packed {
		phase_t     phase;
		logic [1:0] cmd;
		logic [2:0] bit_idx;
		time_t      tc;
		logic [7:0] shift;
		logic [1:0] last_status;
		logic [7:0] read_result;
	} state_t;

	// Duration limit: optionally raised to one tick, then clipped to the timer range.
	function automatic time_t dur_limit(input logic [9:0] d, input logic min_one);
		logic [16:0] w;
		w = 17'(d);
		if (min_one && d == 10'd0) w = 17'd1;
		if (w > TIME_MAX) w = TIME_MAX;
		return time_t'(w);
	endfunction

endpackage

// ----- sv/owm_step.sv -----
`timescale 1ns / 1ps
// Next-state and result logic for one microsecond tick of the bus master.
// Purely combinational; uses owm_pkg for the state, tick, result and config types.
module owm_step (
	input  owm_pkg::state_t st,
	input  owm_pkg::tick_t  tick,
	input  owm_pkg::cfg_t   cfg,
	output owm_pkg::state_t nx,
	output owm_pkg::res_t   res
);

	owm_pkg::state_t  st_eff;
	owm_pkg::time_t   lim_sel;
	owm_pkg::time_t   tc_inc;
	logic             tmr_done;
	logic             done;
	logic             drive;

	// A request is taken only while idle and for a known command.
	always_comb begin
		st_eff = st;
		if (st.phase == owm_pkg::PH_IDLE && tick.start_req &&
				tick.func <= owm_pkg::FUNC_READ) begin
			st_eff.cmd     = tick.func;
			st_eff.bit_idx = 3'd0;
			st_eff.tc      = '0;
			priority if (tick.func == owm_pkg::FUNC_RESET) begin
				st_eff.phase = owm_pkg::PH_RST_LOW;
			end else if (tick.func == owm_pkg::FUNC_WRITE) begin
				st_eff.shift = tick.write_data;
				st_eff.phase = owm_pkg::PH_WR_LOW;
			end else begin
				st_eff.shift = 8'd0;
				st_eff.phase = owm_pkg::PH_RD_PRE;
			end
		end
	end

	always_comb begin
		unique case (st_eff.phase)
			owm_pkg::PH_RST_LOW: lim_sel = owm_pkg::dur_limit(cfg.reset_low_us, 1'b1);
			owm_pkg::PH_RST_REL: lim_sel = owm_pkg::dur_limit(cfg.reset_release_us, 1'b1);
			owm_pkg::PH_PRES,
			owm_pkg::PH_RELW:    lim_sel = owm_pkg::dur_limit(cfg.presence_limit_us, 1'b0);
			owm_pkg::PH_WR_LOW:  lim_sel = owm_pkg::dur_limit(10'(cfg.write_low_us), 1'b1);
			owm_pkg::PH_WR_HOLD: lim_sel = owm_pkg::dur_limit(10'(cfg.write_hold_us), 1'b1);
			owm_pkg::PH_RD_LOW:  lim_sel = owm_pkg::dur_limit(10'(cfg.read_low_us), 1'b1);
			owm_pkg::PH_RD_WAIT: lim_sel = owm_pkg::dur_limit(10'(cfg.read_sample_us), 1'b1);
			owm_pkg::PH_RD_TAIL: lim_sel = owm_pkg::dur_limit(10'(cfg.read_tail_us), 1'b1);
			default:             lim_sel = owm_pkg::dur_limit(10'd1, 1'b1);
		endcase
	end

	assign tc_inc   = st_eff.tc + owm_pkg::time_t'(1);
	assign tmr_done = (tc_inc >= lim_sel);

	// Next state.
	always_comb begin
		nx   = st_eff;
		done = 1'b0;
		unique case (st_eff.phase)
			owm_pkg::PH_IDLE: begin
			end
			owm_pkg::PH_RST_LOW, owm_pkg::PH_RST_REL, owm_pkg::PH_WR_LOW,
			owm_pkg::PH_WR_HOLD, owm_pkg::PH_RD_LOW, owm_pkg::PH_RD_WAIT,
			owm_pkg::PH_RD_TAIL: begin
				if (st_eff.phase == owm_pkg::PH_RD_TAIL && st_eff.tc == '0) begin
					nx.shift = {tick.line_level, st_eff.shift[7:1]};
				end
				if (tmr_done) begin
					nx.tc = '0;
					unique case (st_eff.phase)
						owm_pkg::PH_RST_LOW: nx.phase = owm_pkg::PH_RST_REL;
						owm_pkg::PH_RST_REL: nx.phase = owm_pkg::PH_PRES;
						owm_pkg::PH_WR_LOW:  nx.phase = owm_pkg::PH_WR_HOLD;
						owm_pkg::PH_WR_HOLD: nx.phase = owm_pkg::PH_WR_GAP;
						owm_pkg::PH_RD_LOW:  nx.phase = owm_pkg::PH_RD_WAIT;
						owm_pkg::PH_RD_WAIT: nx.phase = owm_pkg::PH_RD_TAIL;
						default:             nx.phase = owm_pkg::PH_RD_GAP;
					endcase
				end else begin
					nx.tc = tc_inc;
				end
			end
			owm_pkg::PH_PRES, owm_pkg::PH_RELW: begin
				// The limit check comes before the line sample, so a zero limit fails at once.
				priority if (st_eff.tc >= lim_sel || (!(
						(st_eff.phase == owm_pkg::PH_PRES && !tick.line_level) ||
						(st_eff.phase == owm_pkg::PH_RELW && tick.line_level)) &&
						tc_inc >= lim_sel)) begin
					nx.last_status = (st_eff.phase == owm_pkg::PH_PRES) ?
						owm_pkg::ST_NO_PRES : owm_pkg::ST_NO_REL;
					done     = 1'b1;
					nx.phase = owm_pkg::PH_IDLE;
					nx.tc    = '0;
				end else if (st_eff.phase == owm_pkg::PH_PRES && !tick.line_level) begin
					nx.phase = owm_pkg::PH_RELW;
					nx.tc    = '0;
				end else if (st_eff.phase == owm_pkg::PH_RELW && tick.line_level) begin
					nx.last_status = owm_pkg::ST_OK;
					done     = 1'b1;
					nx.phase = owm_pkg::PH_IDLE;
					nx.tc    = '0;
				end else begin
					nx.tc = tc_inc;
				end
			end
			owm_pkg::PH_WR_GAP, owm_pkg::PH_RD_GAP: begin
				if (st_eff.phase == owm_pkg::PH_WR_GAP) begin
					nx.shift = {1'b0, st_eff.shift[7:1]};
				end
				nx.tc = '0;
				if (st_eff.bit_idx == 3'd7) begin
					nx.bit_idx     = 3'd0;
					nx.last_status = owm_pkg::ST_OK;
					done           = 1'b1;
					nx.phase       = owm_pkg::PH_IDLE;
					if (st_eff.phase == owm_pkg::PH_RD_GAP) begin
						nx.read_result = st_eff.shift;
					end
				end else begin
					nx.bit_idx = st_eff.bit_idx + 3'd1;
					nx.phase   = (st_eff.phase == owm_pkg::PH_WR_GAP) ?
						owm_pkg::PH_WR_LOW : owm_pkg::PH_RD_LOW;
				end
			end
			owm_pkg::PH_RD_PRE: begin
				nx.phase = owm_pkg::PH_RD_LOW;
				nx.tc    = '0;
			end
			default: begin
				nx.phase = owm_pkg::PH_IDLE;
			end
		endcase
	end

	// Line drive for the tick.
	always_comb begin
		unique case (st_eff.phase)
			owm_pkg::PH_RST_LOW, owm_pkg::PH_WR_LOW, owm_pkg::PH_RD_LOW: drive = 1'b1;
			owm_pkg::PH_WR_HOLD: drive = ~st_eff.shift[0];
			default:             drive = 1'b0;
		endcase
	end

	assign res.drive_low = drive;
	assign res.busy_res  = (nx.phase != owm_pkg::PH_IDLE);
	assign res.done_res  = done;
	assign res.read_data = nx.read_result;
	assign res.status    = nx.last_status;

endmodule

// ----- sv/onewire_master_byte_engine_unit.sv -----
`timescale 1ns / 1ps
// Top level of the single-wire bus master byte engine: input register, command
// state, configuration registers and result register. Uses owm_pkg and owm_step.
//
//  channel | direction | handshake          | payload
//  tick    | in        | tick_valid/stall   | tick_data  (owm_pkg::tick_t)
//  res     | out       | res_valid/stall    | res_data   (owm_pkg::res_t)
//  cfg     | in        | cfg_valid/ready    | cfg_index, cfg_data
//
// One tick per cycle unless tick_stall; its single result goes via the tick and result registers.
// The tick register feeds the step logic, whose result and new state are stored together.
// A stalled result register holds the tick register, which then raises tick_stall.
// Reset returns the bus state to idle and the configuration registers to their defaults.
// Configuration writes are always accepted, as cfg_ready is held high.
module onewire_master_byte_engine_unit (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              tick_valid,
	output logic                              tick_stall,
	input  owm_pkg::tick_t                    tick_data,
	output logic                              res_valid,
	input  logic                              res_stall,
	output owm_pkg::res_t                     res_data,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [2:0]                        cfg_index,
	input  logic [owm_pkg::CFG_DATA_BITS-1:0] cfg_data
);

	logic            tick_valid_s1;
	owm_pkg::tick_t  tick_s1;
	owm_pkg::state_t st_q;
	owm_pkg::state_t st_nx;
	owm_pkg::res_t   res_nx;
	owm_pkg::cfg_t   cfg_q;
	logic            res_valid_q;
	owm_pkg::res_t   res_q;
	logic            advance;

	assign advance    = tick_valid_s1 && (!res_valid_q || !res_stall);
	assign tick_stall = tick_valid_s1 && !advance;
	assign cfg_ready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_valid_s1 <= 1'b0;
		end else if (!tick_stall) begin
			tick_valid_s1 <= tick_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_valid && !tick_stall) begin
			tick_s1 <= tick_data;
		end
	end

	owm_step u_step (
		.st   (st_q),
		.tick (tick_s1),
		.cfg  (cfg_q),
		.nx   (st_nx),
		.res  (res_nx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '{
				phase:       owm_pkg::PH_IDLE,
				cmd:         2'd0,
				bit_idx:     3'd0,
				tc:          '0,
				shift:       8'd0,
				last_status: owm_pkg::ST_OK,
				read_result: 8'd0
			};
		end else if (advance) begin
			st_q <= st_nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nx;
		end
	end

	assign res_valid = res_valid_q;
	assign res_data  = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= owm_pkg::CFG_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				owm_pkg::REG_RESET_LOW:   cfg_q.reset_low_us      <= cfg_data[9:0];
				owm_pkg::REG_RESET_REL:   cfg_q.reset_release_us  <= cfg_data[9:0];
				owm_pkg::REG_PRES_LIMIT:  cfg_q.presence_limit_us <= cfg_data[9:0];
				owm_pkg::REG_WRITE_LOW:   cfg_q.write_low_us      <= cfg_data[5:0];
				owm_pkg::REG_WRITE_HOLD:  cfg_q.write_hold_us     <= cfg_data[7:0];
				owm_pkg::REG_READ_LOW:    cfg_q.read_low_us       <= cfg_data[5:0];
				owm_pkg::REG_READ_SAMPLE: cfg_q.read_sample_us    <= cfg_data[5:0];
				owm_pkg::REG_READ_TAIL:   cfg_q.read_tail_us      <= cfg_data[7:0];
				default: begin
				end
			endcase
		end
	end

endmodule

// ----- sv/owm_checker.sv -----
`timescale 1ns / 1ps
// Port-level checks for the single-wire bus master, attached by bind.
// Uses owm_pkg for the payload types and status codes.
module owm_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           tick_stall,
	input logic           res_valid,
	input logic           res_stall,
	input owm_pkg::res_t  res_data
);

	// A held result transfer keeps its payload.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(res_data))
		else $error("result payload changed while stalled");

	// The tick side only stalls when a result is waiting and stalled.
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		tick_stall |-> res_valid && res_stall)
		else $error("tick stalled without a stalled result");

	// A finishing tick never reports the bus as still busy.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.done_res |-> !res_data.busy_res)
		else $error("done raised while busy");

	// The line is only pulled low within a command that carries on.
	a_drive_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_data.drive_low |-> res_data.busy_res)
		else $error("line driven low outside a command");

	// Status holds one of the three defined codes.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_data.status == owm_pkg::ST_OK ||
			res_data.status == owm_pkg::ST_NO_PRES ||
			res_data.status == owm_pkg::ST_NO_REL))
		else $error("undefined status code");

endmodule

bind onewire_master_byte_engine_unit owm_checker u_owm_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.tick_stall (tick_stall),
	.res_valid  (res_valid),
	.res_stall  (res_stall),
	.res_data   (res_data)
);
